@@ hdl/skrt_pkg.sv @@
// shared types and codes for the sorted key record table
// command and status codes, cell operations and the link structs between cells
// no dependencies

package skrt_pkg;

  // command field of an input transaction
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  // status field of a result transaction
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FOUND     = 3'd5,
    ST_LISTED    = 3'd6,
    ST_EMPTY     = 3'd7
  } status_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  // control state of the top level
  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } fsm_t;

  localparam int KEY_FIELD_W   = 16;
  localparam int MARKS_FIELD_W = 10;

  // broadcast from the control to all cells
  typedef struct packed {
    cell_op_t                   op;
    logic [KEY_FIELD_W-1:0]     key;
    logic [MARKS_FIELD_W-1:0]   marks;
    logic [KEY_FIELD_W-1:0]     head_key;
    logic [MARKS_FIELD_W-1:0]   head_marks;
  } cell_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                       valid;
    logic                       lt;
    logic [KEY_FIELD_W-1:0]     key;
    logic [MARKS_FIELD_W-1:0]   marks;
  } cell_link_t;

endpackage

@@ hdl/skrt_cell.sv @@
// one slot of the sorted record chain: valid flag, key and marks
// compares its key with the broadcast key and shifts with its neighbors
// depends on skrt_pkg

module skrt_cell import skrt_pkg::*; #(
  parameter int KEY_W = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t here,
  output logic       eq
);

  logic               valid;
  logic               valid_next;
  logic [KEY_W-1:0]   key;
  logic [KEY_W-1:0]   key_next;
  logic [MARKS_FIELD_W-1:0] marks;
  logic [MARKS_FIELD_W-1:0] marks_next;
  logic [KEY_W-1:0]   cmp_key;
  logic               lt;

  // compare against the broadcast key
  assign cmp_key = ctrl.key[KEY_W-1:0];
  assign lt      = valid && (key < cmp_key);
  assign eq      = valid && (key == cmp_key);

  assign here = '{valid: valid, lt: lt, key: KEY_FIELD_W'(key), marks: marks};

  // next contents of the slot
  always_comb begin
    valid_next = valid;
    key_next   = key;
    marks_next = marks;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (!lt) begin
          if (left.lt) begin
            valid_next = 1'b1;
            key_next   = cmp_key;
            marks_next = ctrl.marks;
          end else begin
            valid_next = left.valid;
            key_next   = left.key[KEY_W-1:0];
            marks_next = left.marks;
          end
        end
      end
      OP_DELETE: begin
        if (!lt) begin
          valid_next = right.valid;
          key_next   = right.key[KEY_W-1:0];
          marks_next = right.marks;
        end
      end
      OP_ROTATE: begin
        if (right.valid) begin
          key_next   = right.key[KEY_W-1:0];
          marks_next = right.marks;
        end else if (valid) begin
          key_next   = ctrl.head_key[KEY_W-1:0];
          marks_next = ctrl.head_marks;
        end
      end
      default: begin
        valid_next = valid;
      end
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // record payload
  always_ff @(posedge clk) begin
    key   <= key_next;
    marks <= marks_next;
  end

endmodule

@@ hdl/sorted_key_record_table_unit.sv @@
// top level of the sorted key record table: control, chain of cells, result register
// depends on skrt_pkg and skrt_cell
//
// Usage:
//   Input transactions arrive on s_tvalid/s_tready/s_tdata, each carrying a
//   command (insert, delete, search, list), a key and a marks value. Results
//   leave on m_tvalid/m_tready/m_tdata with m_tlast on the final result of a
//   command. Insert, delete and search give one result each, registered in the
//   cycle after the input transaction; all cells compare their keys with the
//   incoming key at once and shift in that same cycle, so a new command can
//   be taken every cycle while the receiver keeps up.
//   List gives one result per held record in ascending key order, one per
//   cycle while the receiver keeps up, by rotating the chain through its head
//   cell, and restores the order at its end. A list of an empty table gives
//   one empty result.
//   Reset clears the occupancy flags of all cells, the record count and the
//   result valid flag; the table is empty afterwards.
//   When m_tready is low the result register holds, the chain does not move
//   and s_tready stays low until the result is taken.

module sorted_key_record_table_unit import skrt_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // cmd[1:0], key[17:2], marks_in[27:18], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // status[2:0], key_out[18:3], marks_out[28:19],
                                // entry_count[34:29], zero fill
  output logic        m_tlast
);

  localparam int KB = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  fsm_t                     state;
  fsm_t                     state_next;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [IW-1:0]            idx;
  logic [IW-1:0]            idx_next;

  logic                     out_valid;
  status_t                  out_status;
  logic [KEY_FIELD_W-1:0]   out_key;
  logic [MARKS_FIELD_W-1:0] out_marks;
  logic [5:0]               out_count;
  logic                     out_last;

  cmd_t                     cmd;
  logic [KEY_FIELD_W-1:0]   key_in;
  logic [KEY_FIELD_W-1:0]   key_m;
  logic [MARKS_FIELD_W-1:0] marks_in;
  logic                     in_acc;
  logic                     slot_free;
  logic                     hit;
  logic                     full;
  logic                     list_end;
  logic [MARKS_FIELD_W-1:0] found_marks;

  cell_op_t                 cell_op;
  cell_ctrl_t               ctrl;
  cell_link_t               link [CAPACITY];
  logic [CAPACITY-1:0]      eq_vec;
  logic [CAPACITY-1:0]      valid_vec;

  logic                     load;
  status_t                  r_status;
  logic [KEY_FIELD_W-1:0]   r_key;
  logic [MARKS_FIELD_W-1:0] r_marks;
  logic                     r_last;

  // input fields
  assign cmd      = cmd_t'(s_tdata[1:0]);
  assign key_in   = s_tdata[17:2];
  assign marks_in = s_tdata[27:18];
  assign key_m    = KEY_FIELD_W'(key_in[KB-1:0]);
  assign in_acc   = s_tvalid && s_tready;
  assign slot_free = !out_valid || m_tready;

  assign ctrl = '{op: cell_op, key: key_m, marks: marks_in,
                  head_key: link[0].key, head_marks: link[0].marks};

  // chain of cells, boundary links tied off at both ends
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t lft;
    cell_link_t rgt;
    if (i == 0) begin : g_first
      assign lft = '{valid: 1'b1, lt: 1'b1, key: '0, marks: '0};
    end else begin : g_mid_l
      assign lft = link[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rgt = '{valid: 1'b0, lt: 1'b0, key: '0, marks: '0};
    end else begin : g_mid_r
      assign rgt = link[i+1];
    end
    skrt_cell #(.KEY_W(KB)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (lft),
      .right (rgt),
      .here  (link[i]),
      .eq    (eq_vec[i])
    );
    assign valid_vec[i] = link[i].valid;
  end

  // match summary across the chain
  always_comb begin
    found_marks = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_marks = found_marks | (eq_vec[i] ? link[i].marks : '0);
    end
  end

  assign hit      = |eq_vec;
  assign full     = (count == CW'(CAPACITY));
  assign list_end = (CW'(idx) == (count - CW'(1)));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && (cmd == CMD_LIST) && (count != '0)) begin
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        if (slot_free && list_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // cell operation, result and counters
  always_comb begin
    s_tready   = 1'b0;
    cell_op    = OP_HOLD;
    load       = 1'b0;
    r_status   = ST_INSERTED;
    r_key      = '0;
    r_marks    = '0;
    r_last     = 1'b1;
    count_next = count;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        s_tready = slot_free;
        if (in_acc) begin
          load = 1'b1;
          unique case (cmd)
            CMD_INSERT: begin
              if (hit) begin
                r_status = ST_DUPLICATE;
              end else if (full) begin
                r_status = ST_FULL;
              end else begin
                cell_op    = OP_INSERT;
                count_next = count + CW'(1);
                r_status   = ST_INSERTED;
              end
            end
            CMD_DELETE: begin
              if (hit) begin
                cell_op    = OP_DELETE;
                count_next = count - CW'(1);
                r_status   = ST_DELETED;
              end else begin
                r_status = ST_NOT_FOUND;
              end
            end
            CMD_SEARCH: begin
              if (hit) begin
                r_status = ST_FOUND;
                r_key    = key_m;
                r_marks  = found_marks;
              end else begin
                r_status = ST_NOT_FOUND;
              end
            end
            CMD_LIST: begin
              if (count == '0) begin
                r_status = ST_EMPTY;
              end else begin
                load     = 1'b0;
                idx_next = '0;
              end
            end
            default: begin
              r_status = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_LIST: begin
        if (slot_free) begin
          load     = 1'b1;
          cell_op  = OP_ROTATE;
          r_status = ST_LISTED;
          r_key    = link[0].key;
          r_marks  = link[0].marks;
          r_last   = list_end;
          idx_next = idx + IW'(1);
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= r_status;
      out_key    <= r_key;
      out_marks  <= r_marks;
      out_count  <= 6'(count_next);
      out_last   <= r_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'b0, out_count, out_marks, out_key, out_status};

  // record count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("record count above capacity");

  // occupied cells agree with the record count
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("cell occupancy differs from record count");

  // list walk never runs past the held records
  a_list_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |-> (CW'(idx) < count))
    else $error("list index beyond record count");

  // the last listed record returns control to idle
  a_list_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST && slot_free && list_end) |=> (state == S_IDLE && out_last))
    else $error("list did not finish on its last record");

endmodule

@@ tb/sorted_key_record_table_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench for sorted_key_record_table_unit: drives commands, predicts every result
// with its own table model and checks them in order; depends on skrt_pkg and the rtl

module sorted_key_record_table_unit_tb;
  import skrt_pkg::*;

  localparam int TBL_CAPACITY = 32;
  localparam int TBL_KEY_BITS = 16;
  localparam logic [15:0] KEY_MASK = 16'hFFFF >> (16 - TBL_KEY_BITS);
  localparam int RANDOM_ITEMS = 220;
  localparam int PHASE_COUNT  = 4;

  // one expected result transaction
  typedef struct {
    status_t     status;
    logic [15:0] key_out;
    logic [9:0]  marks_out;
    logic [5:0]  entry_count;
    logic        fin;
  } table_result_t;

  // ordered record table model and queue of awaited results
  class record_table_scoreboard;
    logic [15:0]   keys  [TBL_CAPACITY];
    logic [9:0]    marks [TBL_CAPACITY];
    int unsigned   held;
    table_result_t awaited[$];
    int            errors;

    function void push_result(status_t st, logic [15:0] k, logic [9:0] m, logic fin);
      table_result_t r;
      r.status      = st;
      r.key_out     = k;
      r.marks_out   = m;
      r.entry_count = held[5:0];
      r.fin         = fin;
      awaited.push_back(r);
    endfunction

    // work out the results of one accepted command and update the table
    function void note_input(cmd_t cmd, logic [15:0] key_in, logic [9:0] marks_in);
      logic [15:0] k;
      int unsigned pos;
      bit          hit;
      k = key_in & KEY_MASK;
      if (cmd == CMD_LIST) begin
        if (held == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < held; i++)
            push_result(ST_LISTED, keys[i], marks[i], i + 1 == held);
        end
        return;
      end
      // first position whose key is not below k
      pos = 0;
      while (pos < held && keys[pos] < k) pos++;
      hit = (pos < held) && (keys[pos] == k);
      case (cmd)
        CMD_INSERT: begin
          if (hit) begin
            push_result(ST_DUPLICATE, '0, '0, 1'b1);
          end else if (held >= TBL_CAPACITY) begin
            push_result(ST_FULL, '0, '0, 1'b1);
          end else begin
            for (int i = held; i > pos; i--) begin
              keys[i]  = keys[i-1];
              marks[i] = marks[i-1];
            end
            keys[pos]  = k;
            marks[pos] = marks_in;
            held++;
            push_result(ST_INSERTED, '0, '0, 1'b1);
          end
        end
        CMD_DELETE: begin
          if (!hit) begin
            push_result(ST_NOT_FOUND, '0, '0, 1'b1);
          end else begin
            for (int i = pos; i + 1 < held; i++) begin
              keys[i]  = keys[i+1];
              marks[i] = marks[i+1];
            end
            held--;
            push_result(ST_DELETED, '0, '0, 1'b1);
          end
        end
        default: begin
          if (hit) push_result(ST_FOUND, keys[pos], marks[pos], 1'b1);
          else     push_result(ST_NOT_FOUND, '0, '0, 1'b1);
        end
      endcase
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [39:0] data, logic fin);
      table_result_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result transaction: tdata %h tlast %b", data, fin);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (data[2:0] != e.status) begin
        $error("status: expected %0d, actual %0d", e.status, data[2:0]);
        errors++;
      end
      if (data[18:3] != e.key_out) begin
        $error("key_out: expected %h, actual %h", e.key_out, data[18:3]);
        errors++;
      end
      if (data[28:19] != e.marks_out) begin
        $error("marks_out: expected %h, actual %h", e.marks_out, data[28:19]);
        errors++;
      end
      if (data[34:29] != e.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", e.entry_count, data[34:29]);
        errors++;
      end
      if (fin != e.fin) begin
        $error("last: expected %b, actual %b", e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;  // cmd[1:0], key[17:2], marks_in[27:18], zero fill
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // status[2:0], key_out[18:3], marks_out[28:19],
                               // entry_count[34:29], zero fill
  logic        m_tlast;

  int send_idle  = 0;
  int recv_stall = 0;

  record_table_scoreboard sb = new();

  sorted_key_record_table_unit #(
    .CAPACITY(TBL_CAPACITY),
    .KEY_BITS(TBL_KEY_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always #5 clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  // offer one command and wait until it is taken
  task automatic send_cmd(cmd_t cmd, logic [15:0] key_in, logic [9:0] marks_in);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, marks_in, key_in, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(cmd, key_in, marks_in);
  endtask

  // stimulus and end of run
  initial begin
    bit          filling;
    int          full_tries;
    int unsigned pick;
    cmd_t        cmd;
    logic [15:0] key_in;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes of key and marks, head, middle and tail
    send_cmd(CMD_LIST,   16'h0000, 10'h000);
    send_cmd(CMD_SEARCH, 16'h1234, 10'h3FF);
    send_cmd(CMD_DELETE, 16'h1234, 10'h000);
    send_cmd(CMD_INSERT, 16'h8000, 10'h155);
    send_cmd(CMD_INSERT, 16'h0000, 10'h000);
    send_cmd(CMD_INSERT, 16'hFFFF, 10'h3FF);
    send_cmd(CMD_INSERT, 16'h4000, 10'h2AA);
    send_cmd(CMD_INSERT, 16'h8000, 10'h001);
    send_cmd(CMD_SEARCH, 16'h0000, 10'h000);
    send_cmd(CMD_SEARCH, 16'hFFFF, 10'h000);
    send_cmd(CMD_SEARCH, 16'h8001, 10'h000);
    send_cmd(CMD_LIST,   16'hFFFF, 10'h3FF);
    send_cmd(CMD_DELETE, 16'h4000, 10'h000);
    send_cmd(CMD_DELETE, 16'h0000, 10'h000);
    send_cmd(CMD_DELETE, 16'hFFFF, 10'h000);
    send_cmd(CMD_DELETE, 16'hFFFF, 10'h000);
    send_cmd(CMD_LIST,   16'h0000, 10'h000);
    send_cmd(CMD_DELETE, 16'h8000, 10'h000);
    send_cmd(CMD_LIST,   16'h0000, 10'h000);

    // random: alternate between filling the table to full and draining it
    filling    = 1'b1;
    full_tries = 0;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 77; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 77; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
        pick = $urandom_range(0, 99);
        if (filling)
          cmd = pick < 70 ? CMD_INSERT : pick < 75 ? CMD_DELETE :
                pick < 90 ? CMD_SEARCH : CMD_LIST;
        else
          cmd = pick < 70 ? CMD_DELETE : pick < 80 ? CMD_INSERT :
                pick < 92 ? CMD_SEARCH : CMD_LIST;
        // a held key often, so duplicates, hits and deletes happen
        if (sb.held != 0 && $urandom_range(0, 99) < 40)
          key_in = sb.keys[$urandom_range(0, sb.held - 1)];
        else
          key_in = 16'($urandom_range(0, 16'hFFFF));
        if (filling && cmd == CMD_INSERT && sb.held == TBL_CAPACITY) full_tries++;
        send_cmd(cmd, key_in, 10'($urandom_range(0, 10'h3FF)));
        if (filling && full_tries >= 3) begin
          filling = 1'b0;
        end else if (!filling && sb.held == 0) begin
          filling    = 1'b1;
          full_tries = 0;
        end
      end
    end
    s_tvalid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/skrt_pkg.sv
hdl/skrt_cell.sv
hdl/sorted_key_record_table_unit.sv
tb/sorted_key_record_table_unit_tb.sv
